FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ERBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define ERBF_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/erbf_pkg.sv
// Types, constants and the resync sequence table of the escape and resync byte filter.
package erbf_pkg;

	localparam int unsigned SEQ_LEN = 9;
	localparam logic [3:0] SEQ_LAST = 4'(SEQ_LEN - 1);

	localparam logic [7:0] ESC_BYTE = 8'hD3;
	localparam logic [7:0] RESYNC_LEAD = 8'hD2;
	localparam logic [7:0] LF_BYTE = 8'h0A;
	localparam logic [7:0] CR_BYTE = 8'h0D;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [16:0] AGE_MAX = 17'h1FFFF;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [2:0] {
		KIND_FWD,
		KIND_CMD_BYTE,
		KIND_CMD_END,
		KIND_CMD_LONG,
		KIND_RESYNC
	} kind_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} out_req_t;

	typedef struct packed {
		logic accept;
		logic flush_emit;
		logic cmd_read;
		logic cmd_send;
		logic cmd_end;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic go_flush;
		logic go_cmd;
		logic flush_last;
		logic cmd_last;
	} dp_status_t;

	// LF LF 0xD2 E S Y N C LF
	function automatic logic [7:0] resync_byte(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = LF_BYTE;
			4'd1: r = LF_BYTE;
			4'd2: r = RESYNC_LEAD;
			4'd3: r = 8'h45;
			4'd4: r = 8'h53;
			4'd5: r = 8'h59;
			4'd6: r = 8'h4E;
			4'd7: r = 8'h43;
			4'd8: r = LF_BYTE;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/erbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module erbf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 48,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/erbf_ctrl.sv
// Sequencing state machine: item acceptance, flush runs and command line read-out.
module erbf_ctrl import erbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_CMD_RD,
		ST_CMD_SEND,
		ST_CMD_END
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = !status.out_free;
				if (in_valid && status.out_free) begin
					cmd.accept = 1'b1;
					if (status.go_flush)
						state_d = ST_FLUSH;
					else if (status.go_cmd)
						state_d = ST_CMD_RD;
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.flush_emit = 1'b1;
					if (status.flush_last)
						state_d = ST_IDLE;
				end
			end
			ST_CMD_RD: begin
				cmd.cmd_read = 1'b1;
				state_d = ST_CMD_SEND;
			end
			ST_CMD_SEND: begin
				if (status.out_free) begin
					cmd.cmd_send = 1'b1;
					state_d = status.cmd_last ? ST_CMD_END : ST_CMD_RD;
				end
			end
			ST_CMD_END: begin
				if (status.out_free) begin
					cmd.cmd_end = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: hdl/erbf_datapath.sv
// Datapath: match and command state, line store, flush and read-out counters, result register.
module erbf_datapath import erbf_pkg::*; #(
	parameter int unsigned CMD_BUFFER_BYTES = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_req_t     in_data,
	input  logic        out_stall,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        out_valid,
	output out_req_t    out_data
);

	localparam int unsigned LW = $clog2(CMD_BUFFER_BYTES);

	logic [15:0]   timeout_q;
	logic [3:0]    match_len_q;
	logic [16:0]   age_q;
	logic          in_cmd_q;
	logic [LW-1:0] cmd_len_q;
	logic          cmd_ovf_q;
	logic          last_cr_q;
	logic [3:0]    flush_n_q;
	logic [3:0]    flush_idx_q;
	logic          trail_q;
	logic [7:0]    trail_byte_q;
	logic [LW-1:0] emit_len_q;
	logic [LW-1:0] cmd_idx_q;
	logic          out_valid_q;
	out_req_t      out_q;

	logic [7:0]    b;
	logic          seq_hit;
	logic [16:0]   age_inc;
	logic          timed_out;
	logic          strip;
	logic [LW-1:0] line_len;
	logic          store_room;

	logic [3:0]    ml_d;
	logic [16:0]   age_d;
	logic          in_cmd_d;
	logic [LW-1:0] len_d;
	logic          ovf_d;
	logic          cr_d;
	logic [3:0]    fl_n;
	logic          fl_trail;
	logic          imm_valid;
	out_req_t      imm_out;
	logic          go_cmd;
	logic          store_we;

	logic          fl_more;
	out_req_t      fl_item;
	logic [7:0]    ram_rdata;

	assign b = in_data.data_byte;
	assign seq_hit = (b == resync_byte(match_len_q));
	assign age_inc = (age_q == AGE_MAX) ? age_q : age_q + 17'd1;
	assign timed_out = age_inc > {1'b0, timeout_q};
	assign strip = (cmd_len_q != '0) && last_cr_q;
	assign line_len = cmd_len_q - LW'(strip);
	assign store_room = ({1'b0, cmd_len_q} + (LW+1)'(1)) < (LW+1)'(CMD_BUFFER_BYTES);

	// next state and first result of the request on offer
	always_comb begin
		ml_d = match_len_q;
		age_d = age_q;
		in_cmd_d = in_cmd_q;
		len_d = cmd_len_q;
		ovf_d = cmd_ovf_q;
		cr_d = last_cr_q;
		fl_n = '0;
		fl_trail = 1'b0;
		imm_valid = 1'b0;
		imm_out = '{kind: KIND_FWD, value: 8'h00, last: 1'b1};
		go_cmd = 1'b0;
		store_we = 1'b0;

		if (in_data.func == FUNC_TICK) begin
			if (match_len_q != '0) begin
				age_d = age_inc;
				if (timed_out) begin
					fl_n = match_len_q;
					ml_d = '0;
				end
			end
		end else if (in_cmd_q) begin
			if (b == LF_BYTE) begin
				in_cmd_d = 1'b0;
				len_d = '0;
				ovf_d = 1'b0;
				if (cmd_ovf_q) begin
					imm_valid = 1'b1;
					imm_out.kind = KIND_CMD_LONG;
				end else if (line_len == '0) begin
					imm_valid = 1'b1;
					imm_out.kind = KIND_CMD_END;
				end else begin
					go_cmd = 1'b1;
				end
			end else if (!cmd_ovf_q) begin
				if (store_room) begin
					store_we = 1'b1;
					len_d = cmd_len_q + LW'(1);
					cr_d = (b == CR_BYTE);
				end else begin
					ovf_d = 1'b1;
				end
			end
		end else if (b == ESC_BYTE) begin
			fl_n = match_len_q;
			ml_d = '0;
			in_cmd_d = 1'b1;
			len_d = '0;
			ovf_d = 1'b0;
		end else if (seq_hit) begin
			if (match_len_q == '0)
				age_d = '0;
			if (match_len_q == SEQ_LAST) begin
				ml_d = '0;
				imm_valid = 1'b1;
				imm_out.kind = KIND_RESYNC;
			end else begin
				ml_d = match_len_q + 4'd1;
			end
		end else begin
			fl_n = match_len_q;
			if (b == LF_BYTE) begin
				ml_d = 4'd1;
				age_d = '0;
			end else begin
				ml_d = '0;
				fl_trail = 1'b1;
			end
		end

		if (fl_n != '0) begin
			imm_valid = 1'b1;
			imm_out = '{kind: KIND_FWD, value: resync_byte(4'd0),
				last: (fl_n == 4'd1) && !fl_trail};
		end else if (fl_trail) begin
			imm_valid = 1'b1;
			imm_out = '{kind: KIND_FWD, value: b, last: 1'b1};
		end
	end

	// rest of a flush run: held bytes, then the byte that broke the match
	assign fl_more = flush_idx_q < flush_n_q;
	always_comb begin
		if (fl_more)
			fl_item = '{kind: KIND_FWD, value: resync_byte(flush_idx_q),
				last: (flush_idx_q == flush_n_q - 4'd1) && !trail_q};
		else
			fl_item = '{kind: KIND_FWD, value: trail_byte_q, last: 1'b1};
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign status.go_flush = (fl_n > 4'd1) || ((fl_n == 4'd1) && fl_trail);
	assign status.go_cmd = go_cmd;
	assign status.flush_last = fl_item.last;
	assign status.cmd_last = (cmd_idx_q == emit_len_q - LW'(1));

	erbf_ram #(
		.WIDTH(8),
		.DEPTH(CMD_BUFFER_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept && store_we),
		.waddr(cmd_len_q),
		.wdata(b),
		.re   (cmd.cmd_read),
		.raddr(cmd_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			match_len_q <= '0;
			age_q <= '0;
			in_cmd_q <= 1'b0;
			cmd_len_q <= '0;
			cmd_ovf_q <= 1'b0;
			last_cr_q <= 1'b0;
			flush_n_q <= '0;
			flush_idx_q <= '0;
			trail_q <= 1'b0;
			emit_len_q <= '0;
			cmd_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				timeout_q <= cfg_wr_data;
			if ((cmd.accept && imm_valid) || cmd.flush_emit || cmd.cmd_send || cmd.cmd_end)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cmd.accept) begin
				match_len_q <= ml_d;
				age_q <= age_d;
				in_cmd_q <= in_cmd_d;
				cmd_len_q <= len_d;
				cmd_ovf_q <= ovf_d;
				last_cr_q <= cr_d;
				flush_n_q <= fl_n;
				flush_idx_q <= 4'd1;
				trail_q <= fl_trail;
				emit_len_q <= line_len;
				cmd_idx_q <= '0;
			end
			if (cmd.flush_emit) begin
				if (fl_more)
					flush_idx_q <= flush_idx_q + 4'd1;
			end
			if (cmd.cmd_send)
				cmd_idx_q <= cmd_idx_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			trail_byte_q <= b;
			if (imm_valid)
				out_q <= imm_out;
		end
		if (cmd.flush_emit)
			out_q <= fl_item;
		if (cmd.cmd_send)
			out_q <= '{kind: KIND_CMD_BYTE, value: ram_rdata, last: 1'b0};
		if (cmd.cmd_end)
			out_q <= '{kind: KIND_CMD_END, value: 8'h00, last: 1'b1};
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: hdl/escape_and_resync_byte_filter.sv
// Top level of the escape and resync byte filter: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  in       | in_valid / in_stall  | in_data   (func, data_byte)
//  out      | out_valid / out_stall| out_data  (kind, value, last)
//  cfg      | cfg_wr_en            | cfg_wr_data (flush timeout, ticks)
//
// A request with at most one result is accepted from the idle state, its result in the
// output register the cycle after; the next request may be taken at the edge that result leaves.
// A flush run emits each result after the first from the flush state while the output is free
// (up to nine results in all). A command line reads each stored byte from the line store
// (a registered read), then loads it to the output, and ends with an end marker.
// Input stalls for the whole of a run, and whenever the output register is
// full and stalled. Reset clears all control state at once; no clearing pass.
module escape_and_resync_byte_filter import erbf_pkg::*; #(
	parameter int unsigned CMD_BUFFER_BYTES = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_req_t    out_data,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	erbf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	erbf_datapath #(
		.CMD_BUFFER_BYTES(CMD_BUFFER_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.out_stall  (out_stall),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

endmodule

FILE: hdl/erbf_checker.sv
// Port-level checker for the escape and resync byte filter, with its bind.
`include "assert_macros.svh"

module erbf_checker import erbf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input in_req_t     in_data,
	input logic        out_valid,
	input logic        out_stall,
	input out_req_t    out_data,
	input logic        cfg_wr_en,
	input logic [15:0] cfg_wr_data
);

	logic out_blocked;
	logic out_marker;

	assign out_blocked = out_valid && out_stall;
	assign out_marker = out_valid && (out_data.kind == KIND_RESYNC ||
		out_data.kind == KIND_CMD_END || out_data.kind == KIND_CMD_LONG);

	// a stalled result request holds
	`ERBF_ASSERT(a_out_hold, out_blocked |=> out_valid && $stable(out_data), "result changed under stall")

	`ERBF_ASSERT_RST(a_rst_empty, !arst_n |-> !out_valid, "result offered during reset")

	// no new request while the result register is blocked
	`ERBF_ASSERT(a_in_blocked, out_blocked |-> in_stall, "input taken with output blocked")

	`ERBF_ASSERT(a_zero_value, out_marker |-> out_data.value == 8'h00, "marker with non-zero value")

	`ERBF_ASSERT(a_marker_last, out_marker |-> out_data.last, "marker result not last")

endmodule

bind escape_and_resync_byte_filter erbf_checker u_erbf_checker (.*);
